@@ rtl/keyed_masked_counter_table_defines.svh @@
// Assertion macros used by the checker module of the counter table.
`ifndef KEYED_MASKED_COUNTER_TABLE_DEFINES_SVH
`define KEYED_MASKED_COUNTER_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KMCT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KMCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/kmct_pkg.sv @@
// Package with the constants, codes and types of the keyed masked counter table.
package kmct_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int DATA_W      = 64;

   typedef enum logic [1:0] {
      FN_ADD    = 2'd0,
      FN_READ   = 2'd1,
      FN_INC    = 2'd2,
      FN_REMOVE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_DUP       = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_CMP,
      S_PROBE,
      S_HIT,
      S_EXEC,
      S_UP_RD,
      S_UP_WR,
      S_DN_RD,
      S_DN_WR
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] mask;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      logic              lt;
      logic              eq;
      logic [DATA_W-1:0] sum;
   } alu_result_type;

endpackage

@@ rtl/kmct_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module kmct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/kmct_alu.sv @@
// Shared key comparator and masked counter adder.
module kmct_alu
   import kmct_pkg::*;
(
   input  logic [DATA_W-1:0] lhs_key,
   input  logic [DATA_W-1:0] rhs_key,
   input  logic [DATA_W-1:0] value,
   input  logic [DATA_W-1:0] incr,
   input  logic [DATA_W-1:0] mask,
   output alu_result_type    res
);

   always_comb begin
      res.lt  = lhs_key < rhs_key;
      res.eq  = lhs_key == rhs_key;
      res.sum = (value + incr) & mask;
   end

endmodule

@@ rtl/keyed_masked_counter_table.sv @@
// Top level of the keyed masked counter table: sorted row memory, search and shift sequencer.
// A request runs a binary search over the n stored counters, then a probe of the row found and an
// execute step; an add or remove that succeeds then reads and writes each row it moves, and ends.
// The row memory's single read port paces both the binary search and the shift.
// The next request may be accepted in the cycle its predecessor's result is shown.
// The receiver cannot stall; each result is shown for one cycle on rsp_valid.
// Reset empties the table and the sequencer; row memory contents stay undefined.
module keyed_masked_counter_table
   import kmct_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_func,
   input  logic [DATA_W-1:0] req_key,
   input  logic [DATA_W-1:0] req_wrap_mask,
   input  logic [DATA_W-1:0] req_increment,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [DATA_W-1:0] rsp_value,
   output logic [CNT_W-1:0]  rsp_occupancy
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              hit_ff, hit_in;
   row_type           row_ff, row_in;
   func_type          func_ff, func_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0] mask_ff, mask_in;
   logic [DATA_W-1:0] incr_ff, incr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]  rsp_occ_ff, rsp_occ_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_wr_addr;
   row_type           ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   row_type           ram_rd_data;
   logic [ROW_W-1:0]  ram_rd_bits;

   alu_result_type    alu_res;

   logic [CNT_W-1:0]  mid;
   logic [CNT_W-1:0]  idx_dec;
   logic [CNT_W-1:0]  idx_inc;

   kmct_ram #(
      .WIDTH (ROW_W),
      .DEPTH (TABLE_DEPTH)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = row_type'(ram_rd_bits);

   kmct_alu u_alu (
      .lhs_key (ram_rd_data.key),
      .rhs_key (key_ff),
      .value   (row_ff.value),
      .incr    (incr_ff),
      .mask    (row_ff.mask),
      .res     (alu_res)
   );

   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_dec = idx_ff - CNT_W'(1);
   assign idx_inc = idx_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      row_ff        <= row_in;
      func_ff       <= func_in;
      key_ff        <= key_in;
      mask_ff       <= mask_in;
      incr_ff       <= incr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      hit_in        = hit_ff;
      row_in        = row_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      mask_in       = mask_ff;
      incr_in       = incr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_occ_in    = rsp_occ_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in  = func_type'(req_func);
               key_in   = req_key;
               mask_in  = req_wrap_mask;
               incr_in  = req_increment;
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               ram_rd_addr = mid[ADDR_W-1:0];
               state_in    = S_CMP;
            end else begin
               state_in = S_PROBE;
            end
         end
         S_CMP: begin
            if (alu_res.lt) begin
               lo_in = mid + CNT_W'(1);
            end else begin
               hi_in = mid;
            end
            state_in = S_SEARCH;
         end
         S_PROBE: begin
            if (lo_ff < count_ff) begin
               ram_rd_addr = lo_ff[ADDR_W-1:0];
               state_in    = S_HIT;
            end else begin
               hit_in   = 1'b0;
               state_in = S_EXEC;
            end
         end
         S_HIT: begin
            hit_in   = alu_res.eq;
            row_in   = ram_rd_data;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_value_in  = '0;
            state_in      = S_IDLE;
            case (func_ff)
               FN_ADD: begin
                  if (hit_ff) begin
                     rsp_status_in = ST_DUP;
                  end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     rsp_valid_in = 1'b0;
                     idx_in       = count_ff;
                     state_in     = S_UP_RD;
                  end
               end
               FN_READ: begin
                  if (hit_ff) begin
                     rsp_value_in = row_ff.value;
                  end else begin
                     rsp_status_in = ST_NOT_FOUND;
                  end
               end
               FN_INC: begin
                  if (hit_ff) begin
                     ram_we            = 1'b1;
                     ram_wr_addr       = lo_ff[ADDR_W-1:0];
                     ram_wr_data.key   = row_ff.key;
                     ram_wr_data.value = alu_res.sum;
                     ram_wr_data.mask  = row_ff.mask;
                     rsp_value_in      = alu_res.sum;
                  end else begin
                     rsp_status_in = ST_NOT_FOUND;
                  end
               end
               FN_REMOVE: begin
                  if (hit_ff) begin
                     rsp_valid_in = 1'b0;
                     idx_in       = lo_ff;
                     state_in     = S_DN_RD;
                  end else begin
                     rsp_status_in = ST_NOT_FOUND;
                  end
               end
               default: begin
                  rsp_status_in = ST_NOT_FOUND;
               end
            endcase
         end
         S_UP_RD: begin
            if (idx_ff > lo_ff) begin
               ram_rd_addr = idx_dec[ADDR_W-1:0];
               state_in    = S_UP_WR;
            end else begin
               ram_we            = 1'b1;
               ram_wr_addr       = lo_ff[ADDR_W-1:0];
               ram_wr_data.key   = key_ff;
               ram_wr_data.value = '0;
               ram_wr_data.mask  = mask_ff;
               count_in          = count_ff + CNT_W'(1);
               rsp_valid_in      = 1'b1;
               rsp_status_in     = ST_OK;
               rsp_value_in      = '0;
               state_in          = S_IDLE;
            end
         end
         S_UP_WR: begin
            ram_we      = 1'b1;
            ram_wr_addr = idx_ff[ADDR_W-1:0];
            ram_wr_data = ram_rd_data;
            idx_in      = idx_dec;
            state_in    = S_UP_RD;
         end
         S_DN_RD: begin
            if (idx_inc < count_ff) begin
               ram_rd_addr = idx_inc[ADDR_W-1:0];
               state_in    = S_DN_WR;
            end else begin
               count_in      = count_ff - CNT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_value_in  = '0;
               state_in      = S_IDLE;
            end
         end
         S_DN_WR: begin
            ram_we      = 1'b1;
            ram_wr_addr = idx_ff[ADDR_W-1:0];
            ram_wr_data = ram_rd_data;
            idx_in      = idx_inc;
            state_in    = S_DN_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_valid_in) begin
         rsp_occ_in = count_in;
      end
   end

   assign busy          = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

@@ rtl/kmct_checker.sv @@
// Port-level checker for the keyed masked counter table, bound to the top level.
`include "keyed_masked_counter_table_defines.svh"

module kmct_checker
   import kmct_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [1:0]        rsp_status,
   input logic [DATA_W-1:0] rsp_value,
   input logic [CNT_W-1:0]  rsp_occupancy
);

   `KMCT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted request did not raise busy")
   `KMCT_ASSERT_NEXT(a_single_result, clock, reset, rsp_valid, !rsp_valid, "result strobe held for two cycles")
   `KMCT_ASSERT_IMPL(a_occ_range, clock, reset, rsp_valid, rsp_occupancy <= CNT_W'(TABLE_DEPTH), "occupancy above table depth")
   `KMCT_ASSERT_IMPL(a_fail_zero, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_value == '0, "failed request returned a nonzero value")
   `KMCT_ASSERT_IMPL(a_full_occ, clock, reset, rsp_valid && (rsp_status == ST_FULL), rsp_occupancy == CNT_W'(TABLE_DEPTH), "full status with a table that is not full")

endmodule

bind keyed_masked_counter_table kmct_checker u_kmct_checker (.*);
